FILE: design/hex_digit_shift_echo_top_macros.svh
// Assertion macros shared by the hex digit shift echo design files.
`ifndef HEX_DIGIT_SHIFT_ECHO_TOP_MACROS_SVH
`define HEX_DIGIT_SHIFT_ECHO_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HDSE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("hdse: invariant violated");
`define HDSE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdse: implication violated");
`else
`define HDSE_ASSERT_ALWAYS(label, clk, rst, cond)
`define HDSE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/hdse_pkg.sv
// Shared types, character constants and helpers of the hex digit shift echo block.
package hdse_pkg;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_KEY  = 1'b1;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;
   localparam logic [7:0] ASCII_A    = 8'h61;
   localparam logic [7:0] ASCII_F    = 8'h66;
   localparam logic [7:0] ASCII_CR   = 8'h0d;
   localparam logic [7:0] ASCII_LF   = 8'h0a;
   localparam logic [7:0] STATUS_BYTE = 8'h00;

   // Control part of one queued command.
   typedef struct packed {
      logic is_line;
      logic mode_led;
   } cmd_ctrl_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] r;
      if (v <= 4'd9) begin
         r = ASCII_ZERO + {4'd0, v};
      end else begin
         r = ASCII_A + {4'd0, v} - 8'd10;
      end
      return r;
   endfunction

endpackage

FILE: design/hdse_front.sv
// Front end: accepts items, updates digits and mode, queues echo commands.
module hdse_front #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_key_level,
   output logic                       push_valid,
   input  logic                       push_full,
   output hdse_pkg::cmd_ctrl_type     push_ctrl,
   output logic [4*DIGIT_COUNT-1:0]   push_digits
);
   import hdse_pkg::*;

   localparam int DW = 4 * DIGIT_COUNT;

   logic [DW-1:0] digits_ff, digits_in;
   logic          prev_key_ff, prev_key_in;
   logic          insert_left_ff, insert_left_in;

   logic       accept;
   logic       is_key;
   logic       rising;
   logic       char_ok;
   logic [3:0] nibble;

   always_comb begin
      char_ok = 1'b0;
      nibble  = 4'd0;
      if (req_char_code >= ASCII_ZERO && req_char_code <= ASCII_NINE) begin
         char_ok = 1'b1;
         nibble  = 4'(req_char_code - ASCII_ZERO);
      end else if (req_char_code >= ASCII_A && req_char_code <= ASCII_F) begin
         char_ok = 1'b1;
         nibble  = 4'(req_char_code - ASCII_A) + 4'd10;
      end
   end

   assign req_stall = push_full;
   assign accept    = req_valid && !push_full;
   assign is_key    = (req_kind == KIND_KEY);
   assign rising    = req_key_level && !prev_key_ff;

   always_comb begin
      digits_in      = digits_ff;
      prev_key_in    = prev_key_ff;
      insert_left_in = insert_left_ff;
      if (accept) begin
         if (is_key) begin
            prev_key_in = req_key_level;
            if (rising) begin
               insert_left_in = !insert_left_ff;
            end
         end else if (char_ok) begin
            // Digit 0 sits in the low nibble; the first position is digit 0.
            if (insert_left_ff) begin
               digits_in = {digits_ff[DW-5:0], nibble};
            end else begin
               digits_in = {nibble, digits_ff[DW-1:4]};
            end
         end
      end
   end

   assign push_valid        = accept && (is_key ? rising : char_ok);
   assign push_ctrl.is_line  = !is_key;
   assign push_ctrl.mode_led = insert_left_in;
   assign push_digits        = digits_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff      <= '0;
         prev_key_ff    <= 1'b0;
         insert_left_ff <= 1'b0;
      end else begin
         digits_ff      <= digits_in;
         prev_key_ff    <= prev_key_in;
         insert_left_ff <= insert_left_in;
      end
   end

endmodule

FILE: design/hdse_fifo.sv
// Two-entry command queue between the front end and the back end.
`include "hex_digit_shift_echo_top_macros.svh"
module hdse_fifo #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import hdse_pkg::*;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign push_full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ready ? !rd_ptr_ff : rd_ptr_ff;
      case ({push_valid, pop_ready})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HDSE_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= 2'd2)
   `HDSE_ASSERT_IMPLY(a_no_overflow, clock, reset, push_valid, !push_full)
   `HDSE_ASSERT_IMPLY(a_no_underflow, clock, reset, pop_ready, pop_valid)

endmodule

FILE: design/hdse_back.sv
// Back end: expands queued commands into echo line bytes or a status result.
`include "hex_digit_shift_echo_top_macros.svh"
module hdse_back #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   input  hdse_pkg::cmd_ctrl_type   cmd_ctrl,
   input  logic [4*DIGIT_COUNT-1:0] cmd_digits,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last,
   output logic                     rsp_mode_led
);
   import hdse_pkg::*;

   localparam int IDX_W = $clog2(DIGIT_COUNT + 2);
   localparam int DIG_W = $clog2(DIGIT_COUNT);
   localparam logic [IDX_W-1:0] CR_IDX   = IDX_W'(DIGIT_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT + 1);

   logic             busy_ff, busy_in;
   cmd_ctrl_type     ctrl_ff;
   logic [3:0]       digits_ff [DIGIT_COUNT];
   logic [3:0]       cmd_dig [DIGIT_COUNT];
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_byte_valid_ff;
   logic       rsp_last_ff;
   logic       rsp_mode_led_ff;

   logic       out_free;
   logic       advance;
   logic       finish;
   logic [7:0] sel_byte;
   logic       sel_byte_valid;
   logic       sel_last;

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         cmd_dig[i] = cmd_digits[4*i +: 4];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;
   assign finish   = advance && (!ctrl_ff.is_line || idx_ff == LAST_IDX);
   assign cmd_pop  = cmd_valid && (!busy_ff || finish);

   always_comb begin
      if (!ctrl_ff.is_line) begin
         sel_byte       = STATUS_BYTE;
         sel_byte_valid = 1'b0;
         sel_last       = 1'b1;
      end else if (idx_ff == LAST_IDX) begin
         sel_byte       = ASCII_LF;
         sel_byte_valid = 1'b1;
         sel_last       = 1'b1;
      end else if (idx_ff == CR_IDX) begin
         sel_byte       = ASCII_CR;
         sel_byte_valid = 1'b1;
         sel_last       = 1'b0;
      end else begin
         sel_byte       = hex_char(digits_ff[idx_ff[DIG_W-1:0]]);
         sel_byte_valid = 1'b1;
         sel_last       = 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (cmd_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         ctrl_ff   <= cmd_ctrl;
         digits_ff <= cmd_dig;
      end
      if (advance) begin
         rsp_out_byte_ff   <= sel_byte;
         rsp_byte_valid_ff <= sel_byte_valid;
         rsp_last_ff       <= sel_last;
         rsp_mode_led_ff   <= ctrl_ff.mode_led;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_mode_led   = rsp_mode_led_ff;

   `HDSE_ASSERT_IMPLY(a_idx_range, clock, reset, busy_ff, idx_ff <= LAST_IDX)
   `HDSE_ASSERT_IMPLY(a_status_single, clock, reset, busy_ff && !ctrl_ff.is_line, idx_ff == '0)
   `HDSE_ASSERT_IMPLY(a_status_last, clock, reset, rsp_valid_ff && !rsp_byte_valid_ff, rsp_last_ff)

endmodule

FILE: design/hex_digit_shift_echo_top.sv
// A result-producing transaction passes the command queue and the back end's command register
// before its first result shows in the output register. A new transaction is accepted each cycle
// while the two-entry command queue has room; the result port delivers one result per cycle while
// the receiver does not stall; a digit line is DIGIT_COUNT + 2 results and a key status one.
// Reset clears the digits to zero, the key history and mode, the queue and the output valid flag.
module hex_digit_shift_echo_top #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_char_code,
   input  logic       req_key_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_mode_led
);
   import hdse_pkg::*;

   localparam int DW   = 4 * DIGIT_COUNT;
   localparam int CMDW = $bits(cmd_ctrl_type) + DW;

   logic           push_valid;
   logic           push_full;
   cmd_ctrl_type   push_ctrl;
   logic [DW-1:0]  push_digits;
   logic           pop_valid;
   logic           pop_ready;
   logic [CMDW-1:0] pop_data;
   cmd_ctrl_type   pop_ctrl;
   logic [DW-1:0]  pop_digits;

   hdse_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .req_key_level (req_key_level),
      .push_valid    (push_valid),
      .push_full     (push_full),
      .push_ctrl     (push_ctrl),
      .push_digits   (push_digits)
   );

   hdse_fifo #(.WIDTH(CMDW)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  ({push_ctrl, push_digits}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_ctrl   = pop_data[CMDW-1:DW];
   assign pop_digits = pop_data[DW-1:0];

   hdse_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd_pop        (pop_ready),
      .cmd_ctrl       (pop_ctrl),
      .cmd_digits     (pop_digits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_mode_led   (rsp_mode_led)
   );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the hex digit shift echo block.
`timescale 1ns / 100ps

module testbench;
   import hdse_pkg::*;

   localparam int DIGITS      = 4;
   localparam int HOLD_CYCLES = 120;
   localparam int PER_PHASE   = 88;

   typedef enum int {
      PH_STEADY,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE,
      PH_BACKPRESSURE
   } phase_type;

   typedef struct {
      logic [7:0] ch;
      logic       is_line;
      logic       is_last;
      logic       led;
   } echo_byte_type;

   // Tracks the digit register and mode, and holds the echo bytes still owed by the block.
   class echo_line_model_type;
      logic [3:0]     digit_row[DIGITS];
      logic           key_seen;
      logic           left_mode;
      echo_byte_type  owed[$];
      int             mismatches;

      function new();
         foreach (digit_row[i]) digit_row[i] = 4'd0;
         key_seen   = 1'b0;
         left_mode  = 1'b0;
         mismatches = 0;
      endfunction

      function void owe_byte(logic [7:0] ch, logic is_line, logic is_last);
         echo_byte_type b;
         b.ch      = ch;
         b.is_line = is_line;
         b.is_last = is_last;
         b.led     = left_mode;
         owed.push_back(b);
      endfunction

      // Applies one accepted transaction and returns how many echo bytes it causes.
      function int absorb_request(logic kind, logic [7:0] code, logic key);
         logic [3:0] nib;
         logic [7:0] glyph;
         if (kind == KIND_KEY) begin
            if (!(key && !key_seen)) begin
               key_seen = key;
               return 0;
            end
            key_seen  = key;
            left_mode = ~left_mode;
            owe_byte(STATUS_BYTE, 1'b0, 1'b1);
            return 1;
         end
         if (code >= ASCII_ZERO && code <= ASCII_NINE) begin
            nib = 4'(code - ASCII_ZERO);
         end else if (code >= ASCII_A && code <= ASCII_F) begin
            nib = 4'(code - ASCII_A + 8'd10);
         end else begin
            return 0;
         end
         if (left_mode) begin
            for (int i = DIGITS - 1; i > 0; i--) digit_row[i] = digit_row[i - 1];
            digit_row[0] = nib;
         end else begin
            for (int i = 0; i < DIGITS - 1; i++) digit_row[i] = digit_row[i + 1];
            digit_row[DIGITS - 1] = nib;
         end
         for (int i = 0; i < DIGITS; i++) begin
            glyph = (digit_row[i] < 4'd10) ? ASCII_ZERO + 8'(digit_row[i])
                                           : ASCII_A + 8'(digit_row[i]) - 8'd10;
            owe_byte(glyph, 1'b1, 1'b0);
         end
         owe_byte(ASCII_CR, 1'b1, 1'b0);
         owe_byte(ASCII_LF, 1'b1, 1'b1);
         return DIGITS + 2;
      endfunction

      function void check_byte(logic [7:0] ch, logic is_line, logic is_last, logic led);
         echo_byte_type exp_b;
         if (owed.size() == 0) begin
            $display("%0t: result expected none actual byte=%h line=%b last=%b led=%b",
                     $time, ch, is_line, is_last, led);
            mismatches++;
            return;
         end
         exp_b = owed.pop_front();
         if (ch !== exp_b.ch) begin
            $display("%0t: out_byte expected %h actual %h", $time, exp_b.ch, ch);
            mismatches++;
         end
         if (is_line !== exp_b.is_line) begin
            $display("%0t: byte_valid expected %b actual %b", $time, exp_b.is_line, is_line);
            mismatches++;
         end
         if (is_last !== exp_b.is_last) begin
            $display("%0t: last expected %b actual %b", $time, exp_b.is_last, is_last);
            mismatches++;
         end
         if (led !== exp_b.led) begin
            $display("%0t: mode_led expected %b actual %b", $time, exp_b.led, led);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = KIND_CHAR;
   logic [7:0] req_char_code = 8'd0;
   logic       req_key_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last;
   logic       rsp_mode_led;

   phase_type           phase = PH_STEADY;
   int                  rsp_stall_pct = 0;
   int                  send_idle_pct = 0;
   int                  hold_count = 0;
   echo_line_model_type line_model = new();

   hex_digit_shift_echo_top #(.DIGIT_COUNT(DIGITS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_key_level  (req_key_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_mode_led   (rsp_mode_led)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: checks each accepted byte, then picks the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            line_model.check_byte(rsp_out_byte, rsp_byte_valid, rsp_last, rsp_mode_led);
         end
         if (phase == PH_BACKPRESSURE && hold_count < HOLD_CYCLES) begin
            rsp_stall  <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Called right after a rising edge; returns once the transaction has been taken.
   task automatic send_item(input logic kind, input logic [7:0] code, input logic key,
                            output int produced);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_char_code <= code;
      req_key_level <= key;
      do @(posedge clock); while (req_stall);
      produced = line_model.absorb_request(kind, code, key);
   endtask

   // Mostly well-formed digits, some key samples and some arbitrary bytes.
   task automatic run_random(input int target);
      int         done;
      int         produced;
      int         pick;
      logic       kind;
      logic [7:0] code;
      logic       key;
      done = 0;
      while (done < target) begin
         pick = $urandom_range(99);
         code = 8'($urandom_range(255));
         key  = 1'($urandom_range(1));
         kind = KIND_CHAR;
         if (pick < 65) begin
            code = ($urandom_range(1) == 0) ? ASCII_ZERO + 8'($urandom_range(9))
                                            : ASCII_A + 8'($urandom_range(5));
         end else if (pick < 85) begin
            kind = KIND_KEY;
         end
         send_item(kind, code, key, produced);
         done++;
      end
   endtask

   initial begin
      int produced;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: digit extremes, rejected neighbors, key edges and both insert modes.
      send_item(KIND_CHAR, ASCII_ZERO, 1'b1, produced);
      send_item(KIND_CHAR, ASCII_NINE, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_A, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_F, 1'b1, produced);
      send_item(KIND_CHAR, 8'h00, 1'b1, produced);
      send_item(KIND_CHAR, 8'hff, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_ZERO - 8'd1, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_NINE + 8'd1, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_A - 8'd1, 1'b0, produced);
      send_item(KIND_CHAR, ASCII_F + 8'd1, 1'b0, produced);
      send_item(KIND_CHAR, 8'h41, 1'b0, produced);
      send_item(KIND_CHAR, 8'h46, 1'b0, produced);
      send_item(KIND_KEY, 8'h00, 1'b0, produced);
      send_item(KIND_KEY, 8'hff, 1'b1, produced);
      send_item(KIND_KEY, ASCII_ZERO, 1'b1, produced);
      send_item(KIND_CHAR, ASCII_ZERO + 8'd5, 1'b1, produced);
      send_item(KIND_CHAR, ASCII_A + 8'd2, 1'b0, produced);
      send_item(KIND_KEY, 8'h00, 1'b0, produced);
      send_item(KIND_KEY, 8'h55, 1'b1, produced);
      send_item(KIND_CHAR, ASCII_ZERO + 8'd7, 1'b0, produced);

      run_random(PER_PHASE);

      send_idle_pct = 74;
      phase         <= PH_SEND_IDLE;
      run_random(PER_PHASE);

      send_idle_pct = 0;
      phase         <= PH_RECV_STALL;
      rsp_stall_pct <= 74;
      run_random(PER_PHASE);

      send_idle_pct = 37;
      phase         <= PH_BOTH_IDLE;
      rsp_stall_pct <= 37;
      run_random(PER_PHASE);

      // The receiver holds off for a while so the block fills and stalls its input.
      send_idle_pct = 0;
      phase         <= PH_BACKPRESSURE;
      rsp_stall_pct <= 0;
      run_random(PER_PHASE);

      req_valid <= 1'b0;
      while (line_model.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (line_model.mismatches == 0 && line_model.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/hdse_pkg.sv
design/hdse_front.sv
design/hdse_fifo.sv
design/hdse_back.sv
design/hex_digit_shift_echo_top.sv
tb/sv/testbench.sv
